FILE: rtl/core/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define ASSERT_IMP(lbl, a, b) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |-> (b)) \
	else $error("assertion failed");

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define ASSERT_NXT(lbl, a, b) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |=> (b)) \
	else $error("assertion failed");

`else

`define ASSERT_IMP(lbl, a, b)
`define ASSERT_NXT(lbl, a, b)

`endif

`endif

FILE: rtl/core/pip_pkg.sv
package pip_pkg;

	localparam int MaxVerticesDef = 64;
	localparam int CoordBitsDef   = 16;

	localparam logic FUNC_APPEND = 1'b0;
	localparam logic FUNC_TEST   = 1'b1;

	localparam logic STATUS_OK   = 1'b0;
	localparam logic STATUS_FULL = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WALK,
		ST_DRAIN
	} state_t;

endpackage

FILE: rtl/core/point_in_polygon_test.sv
// Append: result strobe in the cycle after the transfer; the next item may start then.
// Test: n stored vertices give n+1 reads of the single-port table, which pass through a pipeline
// (diffs, shared multiplier pair, compare) and a finish step in ST_DRAIN before the strobe.
// An empty table answers a test with a strobe in the cycle after the transfer. busy stays high during a walk.
// arst_n clears the vertex count and control; the vertex table has no reset.
// Results show for one cycle on done and cannot be stalled.
`include "assert_macros.svh"

module point_in_polygon_test #(
	parameter int MAX_VERTICES = pip_pkg::MaxVerticesDef,
	parameter int COORD_BITS   = pip_pkg::CoordBitsDef
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic                         func,
	input  logic                         new_polygon,
	input  logic signed [COORD_BITS-1:0] coord_x,
	input  logic signed [COORD_BITS-1:0] coord_y,
	output logic                         done,
	output logic                         inside_res,
	output logic                         status
);
	import pip_pkg::*;

	localparam int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
	localparam int CW = $clog2(MAX_VERTICES + 1);
	localparam int DW = COORD_BITS + 1;
	localparam int PW = 2 * DW;

	state_t state_q, state_nx;

	logic          accept, is_test, issue, finish, pipe_empty;
	logic [CW-1:0] count_q, rd_cnt_q, rd_prev;
	logic [AW-1:0] rd_addr;
	logic          full;

	logic [2*COORD_BITS-1:0] vtx_mem [MAX_VERTICES];

	logic signed [COORD_BITS-1:0] px_q, py_q;
	logic signed [COORD_BITS-1:0] x1_s1, y1_s1, x2_q, y2_q;
	logic                         v_s1, first_s1;
	logic                         v_s2, straddle_s2, dypos_s2;
	logic signed [DW-1:0]         a_s2, dy_s2, b_s2, c_s2;
	logic                         v_s3, straddle_s3, dypos_s3;
	logic signed [PW-1:0]         lhs_s3, rhs_s3;
	logic                         hit;

	logic inside_q, done_q, inside_res_q, status_q;

	assign accept     = start && !busy;
	assign is_test    = (func == FUNC_TEST);
	assign full       = (count_q == CW'(MAX_VERTICES));
	assign pipe_empty = !v_s1 && !v_s2 && !v_s3;

	// next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && is_test && (count_q != '0))
					state_nx = ST_WALK;
			end
			ST_WALK: begin
				if (rd_cnt_q == count_q)
					state_nx = ST_DRAIN;
			end
			ST_DRAIN: begin
				if (pipe_empty)
					state_nx = ST_IDLE;
			end
			default: state_nx = ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		busy   = 1'b1;
		issue  = 1'b0;
		finish = 1'b0;
		unique case (state_q)
			ST_IDLE:  busy = 1'b0;
			ST_WALK:  issue = 1'b1;
			ST_DRAIN: finish = pipe_empty;
			default:  busy = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_nx;
	end

	// read the last vertex first, then walk from the first one
	assign rd_prev = rd_cnt_q - CW'(1);
	assign rd_addr = (rd_cnt_q == '0) ? AW'(count_q - CW'(1)) : rd_prev[AW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			rd_cnt_q <= '0;
		end else begin
			if (accept && !is_test) begin
				if (new_polygon)
					count_q <= CW'(1);
				else if (!full)
					count_q <= count_q + CW'(1);
			end
			if (accept)
				rd_cnt_q <= '0;
			else if (issue)
				rd_cnt_q <= rd_cnt_q + CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (accept && !is_test) begin
			if (new_polygon)
				vtx_mem[0] <= {coord_x, coord_y};
			else if (!full)
				vtx_mem[count_q[AW-1:0]] <= {coord_x, coord_y};
		end
		if (issue)
			{x1_s1, y1_s1} <= vtx_mem[rd_addr];
	end

	// datapath: diffs, products, compare
	always_ff @(posedge clk) begin
		if (accept) begin
			px_q <= coord_x;
			py_q <= coord_y;
		end
		if (v_s1) begin
			x2_q <= x1_s1;
			y2_q <= y1_s1;
		end
		straddle_s2 <= (y1_s1 > py_q) != (y2_q > py_q);
		dypos_s2    <= (y2_q > y1_s1);
		a_s2        <= DW'(px_q) - DW'(x1_s1);
		dy_s2       <= DW'(y2_q) - DW'(y1_s1);
		b_s2        <= DW'(x2_q) - DW'(x1_s1);
		c_s2        <= DW'(py_q) - DW'(y1_s1);
		straddle_s3 <= straddle_s2;
		dypos_s3    <= dypos_s2;
		lhs_s3      <= PW'(a_s2) * PW'(dy_s2);
		rhs_s3      <= PW'(b_s2) * PW'(c_s2);
	end

	assign hit = straddle_s3 && (dypos_s3 ? (lhs_s3 < rhs_s3) : (lhs_s3 > rhs_s3));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1     <= 1'b0;
			first_s1 <= 1'b0;
			v_s2     <= 1'b0;
			v_s3     <= 1'b0;
			inside_q <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			v_s1     <= issue;
			first_s1 <= issue && (rd_cnt_q == '0);
			// the first read only loads the previous vertex
			v_s2     <= v_s1 && !first_s1;
			v_s3     <= v_s2;
			if (accept)
				inside_q <= 1'b0;
			else if (v_s3 && hit)
				inside_q <= !inside_q;
			done_q   <= (accept && (!is_test || (count_q == '0))) || finish;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			inside_res_q <= 1'b0;
			status_q     <= (!is_test && !new_polygon && full) ? STATUS_FULL : STATUS_OK;
		end else if (finish) begin
			inside_res_q <= inside_q;
			status_q     <= STATUS_OK;
		end
	end

	assign done       = done_q;
	assign inside_res = inside_res_q;
	assign status     = status_q;

	`ASSERT_IMP(a_count_range, 1'b1, count_q <= CW'(MAX_VERTICES))
	`ASSERT_IMP(a_walk_bound, state_q == ST_WALK, (rd_cnt_q <= count_q) && (count_q != '0))
	`ASSERT_NXT(a_test_busy, accept && is_test && (count_q != '0), busy && !done)
	`ASSERT_NXT(a_drain_done, (state_q == ST_DRAIN) && pipe_empty, done && !busy)
	`ASSERT_IMP(a_res_excl, done, !(inside_res && status))

endmodule

FILE: tb/tb_point_in_polygon_test.sv
module tb_point_in_polygon_test;
	timeunit 1ns;
	timeprecision 1ps;

	import pip_pkg::*;

	localparam int MAX_VERTICES = MaxVerticesDef;
	localparam int COORD_BITS   = CoordBitsDef;
	localparam int ITEM_TARGET  = 800;

	typedef logic signed [COORD_BITS-1:0] coord_t;

	typedef struct {
		logic   func;
		logic   new_polygon;
		coord_t x;
		coord_t y;
		int     gap_after;
	} item_t;

	typedef struct packed {
		logic in_poly;
		logic status;
	} verdict_t;

	logic   clk = 1'b0;
	logic   arst_n = 1'b0;
	logic   start = 1'b0;
	logic   func = FUNC_APPEND;
	logic   new_polygon = 1'b0;
	coord_t coord_x = '0;
	coord_t coord_y = '0;
	logic   busy;
	logic   done;
	logic   inside_res;
	logic   status;

	point_in_polygon_test #(
		.MAX_VERTICES(MAX_VERTICES),
		.COORD_BITS  (COORD_BITS)
	) dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.func       (func),
		.new_polygon(new_polygon),
		.coord_x    (coord_x),
		.coord_y    (coord_y),
		.done       (done),
		.inside_res (inside_res),
		.status     (status)
	);

	always #4 clk = ~clk;

	// polygon as the block should hold it
	coord_t poly_x [MAX_VERTICES];
	coord_t poly_y [MAX_VERTICES];
	int     poly_count = 0;

	item_t    pending_items[$];
	verdict_t expected_verdicts[$];
	item_t    next_item;
	verdict_t got_verdict;
	verdict_t want;
	int       gap_left = 0;
	int       errors = 0;
	int       n_appends = 0;
	int       n_dropped = 0;
	int       n_tests = 0;
	int       n_inside = 0;

	// stimulus generator state
	int     queued = 0;
	int     burst_left = 0;
	coord_t shape_x [MAX_VERTICES];
	coord_t shape_y [MAX_VERTICES];
	int     shape_n = 0;
	int     shape_cx = 0;
	int     shape_cy = 0;
	int     shape_span = 16;

	function automatic bit ray_crosses(longint x1, longint y1, longint x2, longint y2,
			longint px, longint py);
		longint dy;
		longint lhs;
		longint rhs;
		if ((y1 > py) == (y2 > py))
			return 1'b0;
		dy  = y2 - y1;
		lhs = (px - x1) * dy;
		rhs = (x2 - x1) * (py - y1);
		if (dy > 0)
			return lhs < rhs;
		return lhs > rhs;
	endfunction

	function automatic verdict_t judge_item(logic f, logic np, coord_t x, coord_t y);
		verdict_t v;
		int j;
		v.in_poly = 1'b0;
		v.status  = STATUS_OK;
		if (f == FUNC_APPEND) begin
			if (np)
				poly_count = 0;
			if (poly_count < MAX_VERTICES) begin
				poly_x[poly_count] = x;
				poly_y[poly_count] = y;
				poly_count++;
			end else begin
				v.status = STATUS_FULL;
			end
		end else begin
			// walk the closing edge first, then each neighbor pair
			j = poly_count - 1;
			for (int i = 0; i < poly_count; i++) begin
				if (ray_crosses(poly_x[i], poly_y[i], poly_x[j], poly_y[j], x, y))
					v.in_poly = ~v.in_poly;
				j = i;
			end
		end
		return v;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start    <= 1'b0;
			gap_left <= 0;
		end else begin
			if (start && !busy) begin
				got_verdict = judge_item(func, new_polygon, coord_x, coord_y);
				expected_verdicts.push_back(got_verdict);
				if (func == FUNC_APPEND) begin
					n_appends++;
					if (got_verdict.status == STATUS_FULL)
						n_dropped++;
				end else begin
					n_tests++;
					if (got_verdict.in_poly)
						n_inside++;
				end
			end
			// slot is free when idle or when this edge completed a transfer
			if (!start || !busy) begin
				if (gap_left > 0) begin
					start    <= 1'b0;
					gap_left <= gap_left - 1;
				end else if (pending_items.size() > 0) begin
					next_item = pending_items.pop_front();
					start       <= 1'b1;
					func        <= next_item.func;
					new_polygon <= next_item.new_polygon;
					coord_x     <= next_item.x;
					coord_y     <= next_item.y;
					gap_left    <= next_item.gap_after;
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && done) begin
			if (expected_verdicts.size() == 0) begin
				$display("%0t: unexpected result, inside_res %b status %b", $time,
					inside_res, status);
				errors++;
			end else begin
				want = expected_verdicts.pop_front();
				if (inside_res !== want.in_poly) begin
					$display("%0t: inside_res expected %b actual %b", $time,
						want.in_poly, inside_res);
					errors++;
				end
				if (status !== want.status) begin
					$display("%0t: status expected %b actual %b", $time,
						want.status, status);
					errors++;
				end
			end
		end
	end

	function automatic coord_t clip(int v);
		if (v > 32767)
			return 16'sh7fff;
		if (v < -32768)
			return 16'sh8000;
		return coord_t'(v);
	endfunction

	function automatic coord_t rnd_near(int c, int s);
		return clip(c + int'($urandom_range(0, 2 * s)) - s);
	endfunction

	function automatic coord_t rnd_word();
		return coord_t'($urandom());
	endfunction

	task automatic queue_item(logic f, logic np, coord_t x, coord_t y);
		item_t it;
		it.func        = f;
		it.new_polygon = np;
		it.x           = x;
		it.y           = y;
		it.gap_after   = 0;
		if (burst_left == 0)
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
				: $urandom_range(1, 12);
		burst_left--;
		if (burst_left == 0)
			it.gap_after = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 80)
				: $urandom_range(1, 10);
		pending_items.push_back(it);
		queued++;
	endtask

	task automatic add_vertex(logic np);
		coord_t x;
		coord_t y;
		x = rnd_near(shape_cx, shape_span);
		y = rnd_near(shape_cy, shape_span);
		if (np)
			shape_n = 0;
		if (shape_n < MAX_VERTICES) begin
			shape_x[shape_n] = x;
			shape_y[shape_n] = y;
			shape_n++;
		end
		queue_item(FUNC_APPEND, np, x, y);
	endtask

	task automatic pick_frame();
		int sc;
		sc = $urandom_range(0, 7);
		if (sc < 4)
			shape_span = 16;
		else if (sc < 6)
			shape_span = 1000;
		else
			shape_span = 32768;
		shape_cx = (shape_span == 32768) ? 0 : int'($urandom_range(0, 65535)) - 32768;
		shape_cy = (shape_span == 32768) ? 0 : int'($urandom_range(0, 65535)) - 32768;
	endtask

	task automatic probe_shape(int k);
		int kind;
		int a;
		int b;
		for (int p = 0; p < k; p++) begin
			kind = $urandom_range(0, 5);
			if (shape_n == 0 && kind >= 2 && kind <= 4)
				kind = 0;
			a = (shape_n > 0) ? $urandom_range(0, shape_n - 1) : 0;
			b = (a + 1 < shape_n) ? a + 1 : 0;
			case (kind)
				0, 1: queue_item(FUNC_TEST, $urandom_range(0, 1),
					rnd_near(shape_cx, shape_span + 2), rnd_near(shape_cy, shape_span + 2));
				2: queue_item(FUNC_TEST, 1'b0, shape_x[a], shape_y[a]);
				3: queue_item(FUNC_TEST, 1'b0,
					rnd_near(shape_cx, shape_span + 2), shape_y[a]);
				4: queue_item(FUNC_TEST, 1'b0,
					clip((int'(shape_x[a]) + int'(shape_x[b])) / 2),
					clip((int'(shape_y[a]) + int'(shape_y[b])) / 2));
				default: queue_item(FUNC_TEST, $urandom_range(0, 1), rnd_word(), rnd_word());
			endcase
		end
	endtask

	initial begin
		int r;
		int n;

		// empty table, then a square spanning the whole coordinate range
		queue_item(FUNC_TEST, 1'b0, 16'sd0, 16'sd0);
		queue_item(FUNC_TEST, 1'b0, 16'sh8000, 16'sh7fff);
		queue_item(FUNC_APPEND, 1'b1, 16'sh8000, 16'sh8000);
		queue_item(FUNC_APPEND, 1'b0, 16'sh7fff, 16'sh8000);
		queue_item(FUNC_APPEND, 1'b0, 16'sh7fff, 16'sh7fff);
		queue_item(FUNC_APPEND, 1'b0, 16'sh8000, 16'sh7fff);
		queue_item(FUNC_TEST, 1'b0, 16'sd0, 16'sd0);
		queue_item(FUNC_TEST, 1'b0, 16'sh8000, 16'sd0);
		queue_item(FUNC_TEST, 1'b0, 16'sh7fff, 16'sd0);
		queue_item(FUNC_TEST, 1'b0, 16'sd0, 16'sh7fff);
		queue_item(FUNC_TEST, 1'b0, 16'sd0, 16'sh8000);
		// one vertex, then two: degenerate edges; then a third vertex
		queue_item(FUNC_APPEND, 1'b1, 16'sd5, 16'sd5);
		queue_item(FUNC_TEST, 1'b0, 16'sd0, 16'sd5);
		queue_item(FUNC_APPEND, 1'b0, 16'sd5, -16'sd5);
		queue_item(FUNC_TEST, 1'b0, 16'sd0, 16'sd0);
		queue_item(FUNC_APPEND, 1'b0, -16'sd5, 16'sd0);
		queue_item(FUNC_TEST, 1'b0, 16'sd0, 16'sd0);
		queue_item(FUNC_TEST, 1'b0, 16'sd5, 16'sd5);
		queue_item(FUNC_TEST, 1'b1, 16'sd0, 16'sd0);
		// square with horizontal edges, points on them and on a crossing
		queue_item(FUNC_APPEND, 1'b1, 16'sd0, 16'sd0);
		queue_item(FUNC_APPEND, 1'b0, 16'sd10, 16'sd0);
		queue_item(FUNC_APPEND, 1'b0, 16'sd10, 16'sd10);
		queue_item(FUNC_APPEND, 1'b0, 16'sd0, 16'sd10);
		queue_item(FUNC_TEST, 1'b0, 16'sd5, 16'sd0);
		queue_item(FUNC_TEST, 1'b0, 16'sd5, 16'sd10);
		queue_item(FUNC_TEST, 1'b0, 16'sd0, 16'sd5);
		queue_item(FUNC_TEST, 1'b0, -16'sd1, 16'sd5);

		while (queued < ITEM_TARGET) begin
			r = $urandom_range(0, 19);
			if (r == 0) begin
				// fill to capacity, overflow, then probe
				pick_frame();
				for (int k = 0; k < MAX_VERTICES; k++)
					add_vertex(k == 0);
				n = $urandom_range(1, 3);
				for (int k = 0; k < n; k++)
					add_vertex(1'b0);
				probe_shape($urandom_range(2, 4));
			end else if (r <= 12) begin
				r = $urandom_range(0, 15);
				if (r == 0)
					n = $urandom_range(1, 2);
				else if (r == 1)
					n = $urandom_range(20, MAX_VERTICES);
				else
					n = $urandom_range(3, 10);
				pick_frame();
				for (int k = 0; k < n; k++)
					add_vertex(k == 0);
				probe_shape($urandom_range(1, 8));
			end else if (r <= 15) begin
				n = $urandom_range(1, 4);
				for (int k = 0; k < n; k++)
					add_vertex(1'b0);
				probe_shape($urandom_range(1, 4));
			end else begin
				n = $urandom_range(1, 5);
				for (int k = 0; k < n; k++)
					queue_item($urandom_range(0, 1), $urandom_range(0, 3) == 0,
						rnd_word(), rnd_word());
			end
		end

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_items.size() != 0 || start)
			@(posedge clk);
		while (expected_verdicts.size() != 0)
			@(posedge clk);
		// let any stray strobe show up
		repeat (100) @(posedge clk);

		$display("Covered %0d vertex appends (%0d dropped on a full table) and %0d point tests,",
			n_appends, n_dropped, n_tests);
		$display("%0d of the tested points inside; %0d mismatches.", n_inside, errors);
		if (errors == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

	initial begin
		#5ms;
		$display("Timeout waiting for results");
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

FILE: sim.f
+incdir+rtl/core
rtl/core/pip_pkg.sv
rtl/core/point_in_polygon_test.sv
tb/tb_point_in_polygon_test.sv
